[src/swm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants for the sliding window maximum block.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Default sizing
  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Configuration register
  localparam int              CFG_WIDTH        = 7;
  localparam logic [CFG_WIDTH-1:0] WINDOW_LEN_RESET = 7'd3;

endpackage : swm_pkg
`default_nettype wire

[src/swm_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swm_in_if
// Sample channel: valid/ready handshake carrying one sample and its end flag.
// ----------------------------------------------------------------------------
interface swm_in_if
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           seq_end;

  modport source (output valid, output sample, output seq_end, input ready);
  modport sink   (input valid, input sample, input seq_end, output ready);
endinterface : swm_in_if
`default_nettype wire

[src/swm_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swm_out_if
// Result channel: valid/ready handshake carrying one window maximum.
// ----------------------------------------------------------------------------
interface swm_out_if
  import swm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] window_max;
  logic                           last_result;

  modport source (output valid, output window_max, output last_result, input ready);
  modport sink   (input valid, input window_max, input last_result, output ready);
endinterface : swm_out_if
`default_nettype wire

[src/swm_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module swm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 23,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : swm_ram
`default_nettype wire

[src/sliding_window_max.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_max
// Running maximum over the last window_len samples using a monotonic deque.
// ----------------------------------------------------------------------------
// Each accepted sample produces the maximum of the window ending at it, once
// window_len samples of the sequence have arrived; seq_end marks the final
// sample, flags its result and starts a fresh sequence. The deque of
// (value, position) pairs lives in a one-read, one-write RAM; head, tail,
// occupancy and counters are registers. One sample at a time: an accept step,
// a tail compare per pass of the RAM read loop (one per entry removed, plus
// one for the entry that stops the scan when any remain), a push step, and an
// emit step when a result is due, which waits for the result register to
// free up. The block takes no new sample until it is through with the last.
// A write to window_len, taken only while idle, clears the sequence state and
// holds off the sample channel for that cycle; values 0 act as 1 and values
// above WINDOW_MAX act as WINDOW_MAX.
// ----------------------------------------------------------------------------
module sliding_window_max
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_WIDTH-1:0] cfg_wdata,
  swm_in_if.sink                    samples,
  swm_out_if.source                 results
);

  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;  // deque index
  localparam int OW = $clog2(WINDOW_MAX + 1);                      // counts
  localparam int PW = $clog2(2 * WINDOW_MAX);                      // stream position
  localparam int EW = SAMPLE_WIDTH + PW;                           // RAM entry

  localparam logic [PW:0]   POS_MOD_W = (PW + 1)'(2 * WINDOW_MAX);
  localparam logic [PW-1:0] POS_LAST  = PW'(2 * WINDOW_MAX - 1);
  localparam logic [IW-1:0] IDX_LAST  = IW'(WINDOW_MAX - 1);
  localparam logic [OW-1:0] OCC_FULL  = OW'(WINDOW_MAX);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i);
    return (i == IDX_LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i);
    return (i == '0) ? IDX_LAST : i - 1'b1;
  endfunction

  // Registers
  logic [1:0]                     state;
  logic [CFG_WIDTH-1:0]           window_len;
  logic signed [SAMPLE_WIDTH-1:0] s_val;
  logic                           s_last;
  logic [IW-1:0]                  head;
  logic [IW-1:0]                  tail;
  logic [OW-1:0]                  occ;
  logic [PW-1:0]                  spos;
  logic [OW-1:0]                  warm;
  logic                           fwd;
  logic                           out_valid;
  logic signed [SAMPLE_WIDTH-1:0] out_max;
  logic                           out_last;

  // RAM ports
  logic          ram_we;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  swm_ram #(
    .DEPTH (WINDOW_MAX),
    .WIDTH (EW),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata ({s_val, spos}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Effective window length
  logic [OW-1:0] k;
  logic [OW-1:0] k_m1;
  always_comb begin
    if (window_len == '0) begin
      k = OW'(1);
    end else if (int'(window_len) > WINDOW_MAX) begin
      k = OCC_FULL;
    end else begin
      k = OW'(window_len);
    end
    k_m1 = k - 1'b1;
  end

  // Position of the oldest sample in the window ending at spos
  logic [PW-1:0] km1_pos;
  logic [PW:0]   oldest_wrap;
  logic [PW-1:0] oldest;
  logic [PW-1:0] spos_inc;
  always_comb begin
    km1_pos     = PW'(k_m1);
    oldest_wrap = {1'b0, spos} + POS_MOD_W - {1'b0, km1_pos};
    oldest      = (spos >= km1_pos) ? (spos - km1_pos) : oldest_wrap[PW-1:0];
    spos_inc    = (spos == POS_LAST) ? '0 : spos + 1'b1;
  end

  // Handshake terms; a register write takes the idle cycle
  logic in_acc;
  logic out_free;
  assign samples.ready = (state == ST_IDLE) && !cfg_we;
  assign in_acc        = samples.valid && samples.ready;
  assign out_free      = !out_valid || results.ready;

  // Tail compare and push/head terms
  logic signed [SAMPLE_WIDTH-1:0] rd_val;
  logic [PW-1:0]                  rd_pos;
  logic                           do_pop;
  logic                           full;
  logic [IW-1:0]                  head_adj;
  logic [OW-1:0]                  occ_adj;
  logic [OW-1:0]                  warm_next;
  logic                           emit_due;
  logic signed [SAMPLE_WIDTH-1:0] hd_val;
  logic [PW-1:0]                  hd_pos;
  always_comb begin
    rd_val    = ram_rdata[EW-1:PW];
    rd_pos    = ram_rdata[PW-1:0];
    do_pop    = (rd_val <= s_val);
    full      = (occ == OCC_FULL);
    head_adj  = full ? idx_next(head) : head;
    occ_adj   = full ? occ - 1'b1 : occ;
    warm_next = (warm < k) ? warm + 1'b1 : warm;
    emit_due  = (warm_next >= k);
    hd_val    = fwd ? s_val : rd_val;
    hd_pos    = fwd ? spos : rd_pos;
  end

  // RAM read address and enables
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_prev(tail);
    ram_we    = 1'b0;
    case (state)
      ST_IDLE: begin
        ram_re = in_acc && (occ != '0);
      end
      ST_POP: begin
        ram_re    = do_pop && (occ > OW'(1));
        ram_raddr = idx_prev(idx_prev(tail));
      end
      ST_PUSH: begin
        ram_we    = 1'b1;
        ram_re    = emit_due;
        ram_raddr = head_adj;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  // Sequencer and deque pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      window_len <= WINDOW_LEN_RESET;
      head       <= '0;
      tail       <= '0;
      occ        <= '0;
      spos       <= '0;
      warm       <= '0;
      fwd        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cfg_we) begin
            window_len <= cfg_wdata;
            head       <= '0;
            tail       <= '0;
            occ        <= '0;
            spos       <= '0;
            warm       <= '0;
          end else if (in_acc) begin
            state <= (occ != '0) ? ST_POP : ST_PUSH;
          end
        end
        ST_POP: begin
          if (do_pop) begin
            tail <= idx_prev(tail);
            occ  <= occ - 1'b1;
            if (occ <= OW'(1)) begin
              state <= ST_PUSH;
            end
          end else begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          fwd <= (occ_adj == '0);
          if (emit_due) begin
            state <= ST_EMIT;
            head  <= head_adj;
            tail  <= idx_next(tail);
            occ   <= occ_adj + 1'b1;
            warm  <= warm_next;
          end else begin
            state <= ST_IDLE;
            if (s_last) begin
              head <= '0;
              tail <= '0;
              occ  <= '0;
              spos <= '0;
              warm <= '0;
            end else begin
              head <= head_adj;
              tail <= idx_next(tail);
              occ  <= occ_adj + 1'b1;
              warm <= warm_next;
              spos <= spos_inc;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
            if (s_last) begin
              head <= '0;
              tail <= '0;
              occ  <= '0;
              spos <= '0;
              warm <= '0;
            end else begin
              spos <= spos_inc;
              if (hd_pos == oldest) begin
                head <= idx_next(head);
                occ  <= occ - 1'b1;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Sample capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_val  <= samples.sample;
      s_last <= samples.seq_end;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_max  <= hd_val;
      out_last <= s_last;
    end
  end

  assign results.valid       = out_valid;
  assign results.window_max  = out_max;
  assign results.last_result = out_last;

endmodule : sliding_window_max
`default_nettype wire
